[design/mwo_pkg.sv]
// Shared types, constants and register codes for the multi-waveform oscillator.
// Holds the elaboration-time builder for the quarter-wave sine table.
// No dependencies.
package mwo_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int WAVE_WIDTH      = SAMPLE_WIDTH + 1;
   localparam int CHANNEL_COUNT   = 2;
   localparam int SINE_ADDR_BITS  = 8;
   localparam int SINE_QTR        = 1 << SINE_ADDR_BITS;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int INCR_WIDTH      = 31;
   localparam int OFFSET_WIDTH    = 16;
   localparam int AMP_WIDTH       = 17;
   localparam int WSEL_WIDTH      = 3;
   localparam int LFSR_WIDTH      = 16;
   localparam int SUM_WIDTH       = WAVE_WIDTH + 1;
   localparam int PROD_WIDTH      = 2 * SUM_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PHASE_INCREMENT = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PHASE_OFFSET    = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AMPLITUDE       = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WAVE_SELECT     = CSR_INDEX_WIDTH'(3);

   localparam logic [WSEL_WIDTH-1:0] WAVE_SINE     = 3'd0;
   localparam logic [WSEL_WIDTH-1:0] WAVE_SQUARE   = 3'd1;
   localparam logic [WSEL_WIDTH-1:0] WAVE_TRIANGLE = 3'd2;
   localparam logic [WSEL_WIDTH-1:0] WAVE_SAW      = 3'd3;
   localparam logic [WSEL_WIDTH-1:0] WAVE_NOISE    = 3'd4;

   localparam logic [INCR_WIDTH-1:0] INCREMENT_LIMIT = 31'd1789569706;
   localparam logic [AMP_WIDTH-1:0]  AMP_UNITY       = 17'd32768;
   localparam logic [LFSR_WIDTH-1:0] LFSR_SEED       = 16'd44257;
   localparam logic [LFSR_WIDTH-1:0] LFSR_TAPS       = 16'hB400;

   localparam logic signed [WAVE_WIDTH-1:0] WAVE_POS_FULL = 17'sd32768;
   localparam logic signed [WAVE_WIDTH-1:0] WAVE_NEG_FULL = -17'sd32768;
   localparam logic signed [WAVE_WIDTH-1:0] WAVE_ZERO     = 17'sd0;

   localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(16384);
   localparam logic signed [PROD_WIDTH-1:0] SAT_MAX    = PROD_WIDTH'(32767);
   localparam logic signed [PROD_WIDTH-1:0] SAT_MIN    = -PROD_WIDTH'(32768);

   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned TAYLOR_DIV1 = 64'd6;
   localparam longint unsigned TAYLOR_DIV2 = 64'd20;
   localparam longint unsigned TAYLOR_DIV3 = 64'd42;
   localparam longint unsigned TAYLOR_DIV4 = 64'd72;
   localparam longint unsigned TAYLOR_DIV5 = 64'd110;
   localparam longint unsigned TAYLOR_DIV6 = 64'd156;
   localparam longint unsigned TAYLOR_DIV7 = 64'd210;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [WAVE_WIDTH-1:0]   wave_type;
   typedef logic [SINE_QTR:0][WAVE_WIDTH-1:0] sine_rom_type;

   function automatic sine_rom_type mwo_sine_rom();
      sine_rom_type   rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          sum;
      longint          v;
      for (int i = 0; i <= SINE_QTR; i++) begin
         x   = (PI_Q30 * longint'(i)) >> (SINE_ADDR_BITS + 1);
         x2  = (x * x) >> 30;
         mag = x;
         sum = longint'(x);
         mag = ((mag * x2) >> 30) / TAYLOR_DIV1;
         sum = sum - longint'(mag);
         mag = ((mag * x2) >> 30) / TAYLOR_DIV2;
         sum = sum + longint'(mag);
         mag = ((mag * x2) >> 30) / TAYLOR_DIV3;
         sum = sum - longint'(mag);
         mag = ((mag * x2) >> 30) / TAYLOR_DIV4;
         sum = sum + longint'(mag);
         mag = ((mag * x2) >> 30) / TAYLOR_DIV5;
         sum = sum - longint'(mag);
         mag = ((mag * x2) >> 30) / TAYLOR_DIV6;
         sum = sum + longint'(mag);
         mag = ((mag * x2) >> 30) / TAYLOR_DIV7;
         sum = sum - longint'(mag);
         v = 0;
         if (sum > 0) begin
            v = longint'((longint'(unsigned'(sum)) * 32768 + (longint'(1) << 29)) >>> 30);
         end
         if (v > 32768) begin
            v = 32768;
         end
         rom[i] = WAVE_WIDTH'(v);
      end
      return rom;
   endfunction

endpackage

[design/mwo_ifs.sv]
// Channel interfaces of the multi-waveform oscillator: request, response, register write.
// Depends on mwo_pkg.
interface mwo_req_if import mwo_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type in_left;
   sample_type in_right;

   modport source (output valid, output in_left, output in_right, input ready);
   modport sink (input valid, input in_left, input in_right, output ready);
endinterface

interface mwo_rsp_if import mwo_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type out_left;
   sample_type out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink (input valid, input out_left, input out_right, output ready);
endinterface

interface mwo_csr_if import mwo_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/multi_waveform_oscillator.sv]
// Multi-waveform oscillator top level: phase accumulator, wave generation, gain and saturation.
// Depends on mwo_pkg and the channel interfaces in mwo_ifs.
//
//   channel    role    carries
//   req_chan   sink    in_left, in_right (one request per sample tick)
//   rsp_chan   source  out_left, out_right
//   csr_chan   sink    index, data (always ready)
//
// Two register stages: the wave is formed from the phase as a request is taken,
// gain and saturation fill the output register once the response side has space.
// One request per cycle while responses drain; rsp valid is set from the first-stage valid.
// A stalled response holds the output register; the first stage still takes one more request.
// Synchronous reset clears the control state, the registers and the phase; noise takes its seed.
module multi_waveform_oscillator import mwo_pkg::*; #(
   parameter int PHASE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   mwo_req_if.sink    req_chan,
   mwo_rsp_if.source  rsp_chan,
   mwo_csr_if.sink    csr_chan
);

   localparam sine_rom_type SINE_ROM = mwo_sine_rom();

   logic [INCR_WIDTH-1:0]   incr_ff, incr_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [AMP_WIDTH-1:0]    amp_ff, amp_in;
   logic [WSEL_WIDTH-1:0]   wsel_ff, wsel_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [LFSR_WIDTH-1:0]   lfsr_ff, lfsr_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   wave_type                s1_wave_ff;
   sample_type              s1_sample_ff [CHANNEL_COUNT];
   sample_type              rsp_sample_ff [CHANNEL_COUNT];
   sample_type              req_sample [CHANNEL_COUNT];
   sample_type              rsp_sample_in [CHANNEL_COUNT];

   logic                    req_fire;
   logic                    rsp_space;
   logic                    s1_take;
   logic                    csr_fire;
   logic [PHASE_BITS-1:0]   phase_sum;
   logic [1:0]              quad;
   logic [SINE_ADDR_BITS-1:0] sine_idx;
   logic [SINE_ADDR_BITS:0] rom_addr;
   logic [WAVE_WIDTH-1:0]   sine_mag;
   logic [15:0]             p16;
   logic [WAVE_WIDTH-1:0]   p16_x2;
   logic signed [WAVE_WIDTH+1:0] tri_wide;
   wave_type                wave_in;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   assign csr_fire  = csr_chan.valid && csr_chan.ready;
   assign csr_data  = csr_chan.data;
   assign csr_chan.ready = 1'b1;

   assign rsp_space = !rsp_valid_ff || rsp_chan.ready;
   assign s1_take   = s1_valid_ff && rsp_space;
   assign req_chan.ready = !s1_valid_ff || rsp_space;
   assign req_fire  = req_chan.valid && req_chan.ready;

   assign req_sample[0] = req_chan.in_left;
   assign req_sample[1] = req_chan.in_right;

   always_comb begin
      incr_in   = incr_ff;
      offset_in = offset_ff;
      amp_in    = amp_ff;
      wsel_in   = wsel_ff;
      if (csr_fire) begin
         unique case (csr_chan.index)
            REG_PHASE_INCREMENT: begin
               incr_in = (csr_data[INCR_WIDTH-1:0] > INCREMENT_LIMIT) ?
                         INCREMENT_LIMIT : csr_data[INCR_WIDTH-1:0];
            end
            REG_PHASE_OFFSET: begin
               offset_in = csr_data[OFFSET_WIDTH-1:0];
            end
            REG_AMPLITUDE: begin
               amp_in = ({1'b0, csr_data[15:0]} > AMP_UNITY) ?
                        AMP_UNITY : {1'b0, csr_data[15:0]};
            end
            REG_WAVE_SELECT: begin
               wsel_in = csr_data[WSEL_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Wave at the current phase
   always_comb begin
      phase_sum = phase_ff + (PHASE_BITS'(offset_ff) << (PHASE_BITS - 16));
      p16       = phase_sum[PHASE_BITS-1 -: 16];
      quad      = phase_sum[PHASE_BITS-1 -: 2];
      sine_idx  = phase_sum[PHASE_BITS-3 -: SINE_ADDR_BITS];
      rom_addr  = quad[0] ? ((SINE_ADDR_BITS+1)'(SINE_QTR) - {1'b0, sine_idx}) :
                            {1'b0, sine_idx};
      sine_mag  = SINE_ROM[rom_addr];
      p16_x2    = {p16, 1'b0};
      tri_wide  = $signed({2'b00, p16_x2});
      if (p16 >= 16'd49152) begin
         tri_wide = $signed({2'b00, p16_x2}) - (WAVE_WIDTH+2)'(131072);
      end else if (p16 >= 16'd16384) begin
         tri_wide = (WAVE_WIDTH+2)'(65536) - $signed({2'b00, p16_x2});
      end
      unique case (wsel_ff)
         WAVE_SINE:     wave_in = quad[1] ? -$signed(sine_mag) : $signed(sine_mag);
         WAVE_SQUARE:   wave_in = p16[15] ? WAVE_NEG_FULL : WAVE_POS_FULL;
         WAVE_TRIANGLE: wave_in = tri_wide[WAVE_WIDTH-1:0];
         WAVE_SAW:      wave_in = $signed({{2{~p16[15]}}, p16[14:0]});
         WAVE_NOISE:    wave_in = $signed({{2{~lfsr_ff[15]}}, lfsr_ff[14:0]});
         default:       wave_in = WAVE_ZERO;
      endcase
   end

   // Advance the phase on each accepted request, and the noise LFSR while noise is selected
   always_comb begin
      phase_in = phase_ff;
      lfsr_in  = lfsr_ff;
      if (req_fire) begin
         phase_in = phase_ff + PHASE_BITS'(incr_ff);
         if (wsel_ff == WAVE_NOISE) begin
            lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Gain, rounding and saturation per channel
   for (genvar ch = 0; ch < CHANNEL_COUNT; ch++) begin : g_chan
      logic signed [SUM_WIDTH-1:0]  sum;
      logic signed [SUM_WIDTH-1:0]  amp_s;
      logic signed [PROD_WIDTH-1:0] prod;
      logic signed [PROD_WIDTH-1:0] scaled;

      always_comb begin
         sum    = SUM_WIDTH'(s1_sample_ff[ch]) + SUM_WIDTH'(s1_wave_ff);
         amp_s  = $signed({1'b0, amp_ff});
         prod   = PROD_WIDTH'(sum) * PROD_WIDTH'(amp_s);
         scaled = (prod + ROUND_HALF) >>> 15;
         if (scaled > SAT_MAX) begin
            rsp_sample_in[ch] = SAT_MAX[SAMPLE_WIDTH-1:0];
         end else if (scaled < SAT_MIN) begin
            rsp_sample_in[ch] = SAT_MIN[SAMPLE_WIDTH-1:0];
         end else begin
            rsp_sample_in[ch] = scaled[SAMPLE_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         incr_ff      <= '0;
         offset_ff    <= '0;
         amp_ff       <= '0;
         wsel_ff      <= WAVE_SINE;
         phase_ff     <= '0;
         lfsr_ff      <= LFSR_SEED;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         incr_ff      <= incr_in;
         offset_ff    <= offset_in;
         amp_ff       <= amp_in;
         wsel_ff      <= wsel_in;
         phase_ff     <= phase_in;
         lfsr_ff      <= lfsr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_wave_ff <= wave_in;
         for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            s1_sample_ff[ch] <= req_sample[ch];
         end
      end
      if (s1_take) begin
         for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            rsp_sample_ff[ch] <= rsp_sample_in[ch];
         end
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_left  = rsp_sample_ff[0];
   assign rsp_chan.out_right = rsp_sample_ff[1];

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for multi_waveform_oscillator: a directed plan, then random phases.
// Predicts every output pair from its own model of the oscillator state and registers.
// Depends on mwo_pkg, the channel interfaces in mwo_ifs and the block itself.
module tb_top;
   import mwo_pkg::*;

   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 8;
   localparam int STALL_LIMIT     = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int HOLD_PHASE      = 3;
   localparam int HOLD_ITEM       = 20;
   localparam int FULL_SCALE      = 32768;

   localparam longint unsigned PI_FIXED   = 64'd3373259426;
   localparam logic [30:0]     TUNING_MAX = 31'd1789569706;
   localparam logic [15:0]     NOISE_SEED = 16'd44257;
   localparam logic [15:0]     NOISE_TAPS = 16'hB400;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NONE_LOW  = 8'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NONE_HIGH = 8'd255;
   localparam logic [WSEL_WIDTH-1:0] WAVE_UNUSED_FIRST  = 3'd5;
   localparam logic [WSEL_WIDTH-1:0] WAVE_UNUSED_MID    = 3'd6;
   localparam logic [WSEL_WIDTH-1:0] WAVE_UNUSED_LAST   = 3'd7;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
      sample_type                 left;
      sample_type                 right;
      logic                       typed;
      sample_type                 exp_left;
      sample_type                 exp_right;
   } plan_row_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } sample_pair_type;

   typedef struct packed {
      int unsigned seq;
      sample_type  left;
      sample_type  right;
   } pinned_pair_type;

   localparam int PLAN_ROWS = 47;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd32767, -16'sd32768, 1'b1, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, -16'sd1, 16'sd1, 1'b1, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_AMPLITUDE, 32'h0000_FFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_WAVE_SELECT, 32'(WAVE_UNUSED_FIRST), 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767, -16'sd32768},
      '{ROW_SAMPLE, 8'd0, 32'd0, -16'sd1, 16'sd1, 1'b1, -16'sd1, 16'sd1},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd21845, 1'b1, 16'sd0, 16'sd21845},
      '{ROW_WRITE, REG_WAVE_SELECT, 32'(WAVE_SQUARE), 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b1, 16'sd32767, 16'sd32767},
      '{ROW_SAMPLE, 8'd0, 32'd0, -16'sd32768, -16'sd1, 1'b1, 16'sd0, 16'sd32767},
      '{ROW_WRITE, REG_PHASE_OFFSET, 32'h0000_8000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd32767, 1'b1, -16'sd32768, -16'sd1},
      '{ROW_WRITE, REG_WAVE_SELECT, 32'(WAVE_UNUSED_LAST), 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_NONE_LOW, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_NONE_HIGH, 32'h0000_0001, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd12345, -16'sd12345, 1'b1, 16'sd12345, -16'sd12345},
      '{ROW_WRITE, REG_PHASE_INCREMENT, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_PHASE_OFFSET, 32'h0000_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_AMPLITUDE, 32'h0000_8000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_WAVE_SELECT, 32'(WAVE_SINE), 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, -16'sd32768, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd16384, -16'sd16384, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_WAVE_SELECT, 32'(WAVE_TRIANGLE), 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_PHASE_INCREMENT, 32'h0123_4567, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd1000, -16'sd1000, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, -16'sd32768, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_WAVE_SELECT, 32'(WAVE_SAW), 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_AMPLITUDE, 32'h0000_4000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd32767, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd100, -16'sd100, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_WAVE_SELECT, 32'(WAVE_NOISE), 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_AMPLITUDE, 32'h0000_8000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_PHASE_OFFSET, 32'h0000_FFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd32767, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, -16'sd1, 16'sd1, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_WAVE_SELECT, 32'(WAVE_UNUSED_MID), 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_AMPLITUDE, 32'h0000_0001, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd32767, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_WRITE, REG_AMPLITUDE, 32'h0000_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_SAMPLE, 8'd0, 32'd0, 16'sd32767, -16'sd32768, 1'b1, 16'sd0, 16'sd0}
   };

   logic clock = 1'b0;
   logic reset;

   mwo_req_if req_chan ();
   mwo_rsp_if rsp_chan ();
   mwo_csr_if csr_chan ();

   multi_waveform_oscillator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // oscillator state and registers as the block should hold them
   logic [31:0] osc_phase   = '0;
   logic [15:0] lfsr_state  = NOISE_SEED;
   logic [30:0] tuning_word = '0;
   logic [15:0] offset_word = '0;
   int          gain        = 0;
   logic [2:0]  wave_mode   = WAVE_SINE;
   int          quarter_sine [SINE_QTR+1];

   sample_pair_type pending_outputs [$];
   pinned_pair_type pinned_outputs [$];
   int unsigned  samples_sent   = 0;
   int unsigned  responses_seen = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  quiet_cycles   = 0;
   int           burst_left     = 0;
   bit           hold_off_request = 1'b0;

   always #2 clock = ~clock;

   initial begin : sine_build
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          sum;
      for (int i = 0; i <= SINE_QTR; i++) begin
         x   = (PI_FIXED * longint'(i)) / 64'(2 * SINE_QTR);
         x2  = (x * x) >> 30;
         mag = x;
         sum = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            mag = ((mag * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(mag);
            else sum = sum + longint'(mag);
         end
         quarter_sine[i] = (sum > 0) ? int'((sum * 32768 + (64'sd1 <<< 29)) >>> 30) : 0;
         if (quarter_sine[i] > FULL_SCALE) quarter_sine[i] = FULL_SCALE;
      end
   end

   function automatic void apply_csr_write(logic [CSR_INDEX_WIDTH-1:0] index,
                                           logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         REG_PHASE_INCREMENT: tuning_word = (data[30:0] > TUNING_MAX) ? TUNING_MAX : data[30:0];
         REG_PHASE_OFFSET:    offset_word = data[15:0];
         REG_AMPLITUDE:       gain = (int'(data[15:0]) > FULL_SCALE) ? FULL_SCALE : int'(data[15:0]);
         REG_WAVE_SELECT:     wave_mode = data[2:0];
         default: ;
      endcase
   endfunction

   function automatic sample_type scale_channel(sample_type sample, int wave);
      longint prod;
      prod = ((longint'(sample) + longint'(wave)) * longint'(gain) + 64'sd16384) >>> 15;
      if (prod > 64'sd32767) prod = 64'sd32767;
      if (prod < -64'sd32768) prod = -64'sd32768;
      return sample_type'(prod);
   endfunction

   function automatic sample_pair_type synth_output(sample_type left, sample_type right);
      logic [31:0] ph;
      logic [15:0] p16;
      logic [7:0]  entry;
      int          level;
      int          wave;
      ph    = osc_phase + {offset_word, 16'h0000};
      p16   = ph[31:16];
      entry = ph[29:22];
      case (wave_mode)
         WAVE_SINE: begin
            level = ph[30] ? quarter_sine[SINE_QTR - int'(entry)] : quarter_sine[int'(entry)];
            wave  = ph[31] ? -level : level;
         end
         WAVE_SQUARE: wave = p16[15] ? -FULL_SCALE : FULL_SCALE;
         WAVE_TRIANGLE: begin
            if (p16 < 16'd16384) wave = 2 * int'(p16);
            else if (p16 < 16'd49152) wave = 65536 - 2 * int'(p16);
            else wave = 2 * int'(p16) - 131072;
         end
         WAVE_SAW: wave = int'(p16) - FULL_SCALE;
         WAVE_NOISE: begin
            wave       = int'(lfsr_state) - FULL_SCALE;
            lfsr_state = lfsr_state[0] ? ((lfsr_state >> 1) ^ NOISE_TAPS) : (lfsr_state >> 1);
         end
         default: wave = 0;
      endcase
      osc_phase = osc_phase + 32'(tuning_word);
      return '{scale_channel(left, wave), scale_channel(right, wave)};
   endfunction

   function automatic void check_channel(string what, sample_type want, sample_type got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(0, 7))
         0: return 16'sd32767;
         1: return -16'sd32768;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin : scoreboard
      sample_pair_type want;
      pinned_pair_type pin;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) apply_csr_write(csr_chan.index, csr_chan.data);
         if (req_chan.valid && req_chan.ready) begin
            pending_outputs.push_back(synth_output(req_chan.in_left, req_chan.in_right));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_outputs.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response: expected none, got %0d %0d",
                        $time, rsp_chan.out_left, rsp_chan.out_right);
            end else begin
               want = pending_outputs.pop_front();
               check_channel("out_left", want.left, rsp_chan.out_left);
               check_channel("out_right", want.right, rsp_chan.out_right);
            end
            if (pinned_outputs.size() != 0 && pinned_outputs[0].seq == responses_seen) begin
               pin = pinned_outputs.pop_front();
               check_channel("pinned out_left", pin.left, rsp_chan.out_left);
               check_channel("pinned out_right", pin.right, rsp_chan.out_right);
            end
            responses_seen++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      rx_mode_type mode;
      int          span;
      int          rx_tick;
      rx_tick = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            mode = rx_mode_type'($urandom_range(0, 3));
            span = $urandom_range(8, 96);
            repeat (span) begin
               case (mode)
                  RX_OPEN:   rsp_chan.ready <= 1'b1;
                  RX_COIN:   rsp_chan.ready <= ($urandom_range(0, 1) == 1);
                  RX_THIRD:  rsp_chan.ready <= (rx_tick % 3 == 0);
                  RX_MOSTLY: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
                  default:   rsp_chan.ready <= 1'b1;
               endcase
               rx_tick++;
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_sample(input sample_type left, input sample_type right);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid    <= 1'b1;
      req_chan.in_left  <= left;
      req_chan.in_right <= right;
      do @(posedge clock); while (!req_chan.ready);
      samples_sent++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic end_writes();
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // drop the request valid and wait until every predicted output has been seen
   task automatic settle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      plan_row_type row;
      logic [30:0]  inc_word;
      logic [15:0]  amp_word;
      logic [2:0]   wave_word;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.in_left  <= '0;
      req_chan.in_right <= '0;
      csr_chan.valid    <= 1'b0;
      csr_chan.index    <= '0;
      csr_chan.data     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         if (row.kind == ROW_WRITE) begin
            if (r == 0 || DIRECTED_PLAN[r-1].kind == ROW_SAMPLE) settle();
            write_register(row.index, row.data);
            if (r == PLAN_ROWS - 1 || DIRECTED_PLAN[r+1].kind == ROW_SAMPLE) end_writes();
         end else begin
            if (row.typed) pinned_outputs.push_back('{samples_sent, row.exp_left, row.exp_right});
            send_sample(row.left, row.right);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 5))
            0: inc_word = '0;
            1: inc_word = TUNING_MAX;
            2: inc_word = TUNING_MAX + 31'd1;
            3: inc_word = 31'($urandom);
            4: inc_word = 31'($urandom_range(1, 32'h00FF_FFFF));
            default: inc_word = 31'($urandom_range(0, 32'(TUNING_MAX)));
         endcase
         case ($urandom_range(0, 3))
            0: amp_word = '0;
            1: amp_word = 16'(FULL_SCALE);
            2: amp_word = 16'($urandom);
            default: amp_word = 16'($urandom_range(0, FULL_SCALE));
         endcase
         wave_word = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
         write_register(REG_PHASE_INCREMENT, {($urandom_range(0, 1) == 1), inc_word});
         write_register(REG_PHASE_OFFSET, $urandom);
         write_register(REG_AMPLITUDE, {16'($urandom), amp_word});
         write_register(REG_WAVE_SELECT, {29'($urandom), wave_word});
         if ($urandom_range(0, 2) == 0) begin
            write_register(8'($urandom_range(32'(REG_NONE_LOW), 32'(REG_NONE_HIGH))), $urandom);
         end
         end_writes();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == HOLD_PHASE && n == HOLD_ITEM) hold_off_request = 1'b1;
            send_sample(random_sample(), random_sample());
         end
      end

      settle();
      if (mismatch_count == 0 && pending_outputs.size() == 0 && pinned_outputs.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
design/mwo_pkg.sv
design/mwo_ifs.sv
design/multi_waveform_oscillator.sv
tb/tb_top.sv
